@@ hdl/pms_pkg.sv @@
// Shared types and constants of the minimum spanning tree engine.
package pms_pkg;

  localparam int VERTICES_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_UPDATE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic shift;
    logic update;
    logic init;
  } cell_ctrl_t;

endpackage

@@ hdl/prim_minimum_spanning_tree.sv @@
// Top level of the minimum spanning tree engine: weight memory, sequencer and cell row.
//
// Requests arrive on the s_axis channel. With tuser at the write code a request stores
// one weight in the VERTICES x VERTICES matrix; rows or columns out of range are dropped.
// With tuser at the compute code the block grows a tree with Prim's method from
// start_vertex (taken modulo VERTICES) and holds tready low for the run.
// Each added vertex gives one m_axis result of parent, child and edge cost; tlast marks
// the final one. If no outside vertex is reachable, one result with tuser high and
// tlast high ends the run. After reset the matrix is swept to the no-edge code, one
// entry per cycle, before the first request is taken. A compute first reduces the start
// vertex, then for each result reads a matrix row through the single read port into the
// cell row, relaxes the cells, passes the minimum search along the cells and loads the
// output register. A stalled receiver holds the run in its emit step; the output
// register lets the next row load start once a result is stored.
module prim_minimum_spanning_tree #(
  parameter int VERTICES    = pms_pkg::VERTICES_DEF,
  parameter int WEIGHT_BITS = pms_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start_vertex_wr_en,
  input  logic [3:0]  start_vertex_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // row[3:0], col[7:4], weight[23:8]
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // parent_vertex[3:0], child_vertex[7:4], edge_cost[23:8]
  output logic        m_axis_tuser,   // disconnected
  output logic        m_axis_tlast    // last
);
  import pms_pkg::*;

  localparam int VB      = $clog2(VERTICES);
  localparam int ENTRIES = VERTICES * VERTICES;
  localparam int AW      = $clog2(ENTRIES);
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

  state_t state, state_next;

  logic [WEIGHT_BITS-1:0] mem [ENTRIES];
  logic [WEIGHT_BITS-1:0] rdata;
  logic [AW-1:0]          ccnt;
  logic [3:0]             start_vertex;
  logic [3:0]             red;
  logic [VB-1:0]          k;
  logic [VB:0]            ic;
  logic                   rd_vld;
  logic [VB-1:0]          sc;
  logic [VB-1:0]          scnt;
  logic [VB-1:0]          e;
  logic                   init;
  logic                   o_vld;
  logic [3:0]             o_par;
  logic [3:0]             o_child;
  logic [15:0]            o_cost;
  logic                   o_disc;
  logic                   o_last;

  logic [3:0]             in_row;
  logic [3:0]             in_col;
  logic [WEIGHT_BITS-1:0] in_w;
  logic                   acc;
  logic                   wr_ok;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic                   out_free;
  logic                   emit_now;
  logic                   last_res;
  cell_ctrl_t             ctrl;

  logic [WEIGHT_BITS-1:0] wch   [VERTICES+1];
  logic                   cvld  [VERTICES+1];
  logic [WEIGHT_BITS-1:0] ccost [VERTICES+1];
  logic [VB-1:0]          cidx  [VERTICES+1];
  logic [VB-1:0]          cpar  [VERTICES+1];

  assign in_row   = s_axis_tdata[3:0];
  assign in_col   = s_axis_tdata[7:4];
  assign in_w     = WEIGHT_BITS'(s_axis_tdata[23:8]);
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign wr_ok    = (32'(in_row) < VERTICES) && (32'(in_col) < VERTICES);
  assign waddr    = AW'(32'(in_row) * VERTICES + 32'(in_col));
  assign raddr    = AW'(32'(k) * VERTICES + 32'(ic));
  assign out_free = !o_vld || m_axis_tready;
  assign last_res = (32'(e) == VERTICES - 2);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = o_vld;
  assign m_axis_tdata  = {o_cost, o_child, o_par};
  assign m_axis_tuser  = o_disc;
  assign m_axis_tlast  = o_last;

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem[ccnt] <= NO_EDGE;
    end else if (acc && (s_axis_tuser == OP_WRITE) && wr_ok) begin
      mem[waddr] <= in_w;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next  = state;
    ctrl.shift  = rd_vld;
    ctrl.update = 1'b0;
    ctrl.init   = init;
    emit_now    = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (32'(ccnt) == ENTRIES - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc && (s_axis_tuser == OP_COMPUTE)) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (32'(red) < VERTICES) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (rd_vld && (32'(sc) == VERTICES - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ctrl.update = 1'b1;
        state_next  = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (32'(scnt) == VERTICES - 1) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_now = 1'b1;
          if (!cvld[VERTICES] || last_res) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      ccnt         <= '0;
      start_vertex <= '0;
      o_vld        <= 1'b0;
      rd_vld       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        ccnt <= ccnt + 1'b1;
      end
      if (start_vertex_wr_en) begin
        start_vertex <= start_vertex_wr_data;
      end
      rd_vld <= (state == ST_LOAD) && (32'(ic) < VERTICES);
      if (emit_now) begin
        o_vld <= 1'b1;
      end else if (m_axis_tready) begin
        o_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        red <= start_vertex;
      end
      ST_REDUCE: begin
        if (32'(red) < VERTICES) begin
          k    <= VB'(red);
          init <= 1'b1;
          e    <= '0;
          ic   <= '0;
          sc   <= '0;
        end else begin
          red <= red - 4'(VERTICES);
        end
      end
      ST_LOAD: begin
        if (32'(ic) < VERTICES) begin
          ic <= ic + 1'b1;
        end
        if (rd_vld) begin
          sc <= sc + 1'b1;
        end
      end
      ST_UPDATE: begin
        init <= 1'b0;
        scnt <= '0;
      end
      ST_SEARCH: begin
        scnt <= scnt + 1'b1;
      end
      ST_EMIT: begin
        if (emit_now) begin
          ic <= '0;
          sc <= '0;
          if (cvld[VERTICES]) begin
            o_par   <= 4'(cpar[VERTICES]);
            o_child <= 4'(cidx[VERTICES]);
            o_cost  <= 16'(ccost[VERTICES]);
            o_disc  <= 1'b0;
            o_last  <= last_res;
            k       <= cidx[VERTICES];
            e       <= e + 1'b1;
          end else begin
            o_par   <= '0;
            o_child <= '0;
            o_cost  <= '0;
            o_disc  <= 1'b1;
            o_last  <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign wch[VERTICES] = rdata;
  assign cvld[0]       = 1'b0;
  assign ccost[0]      = '0;
  assign cidx[0]       = '0;
  assign cpar[0]       = '0;

  for (genvar i = 0; i < VERTICES; i++) begin : g_cell
    pms_cell #(
      .VERTICES    (VERTICES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .IDX         (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .k         (k),
      .w_in      (wch[i+1]),
      .w_out     (wch[i]),
      .cin_vld   (cvld[i]),
      .cin_cost  (ccost[i]),
      .cin_idx   (cidx[i]),
      .cin_par   (cpar[i]),
      .cout_vld  (cvld[i+1]),
      .cout_cost (ccost[i+1]),
      .cout_idx  (cidx[i+1]),
      .cout_par  (cpar[i+1])
    );
  end

  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    (acc && (s_axis_tuser == OP_COMPUTE)) |=> !s_axis_tready)
    else $error("Input still ready after a compute request.");

  a_disc_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("Disconnected result is not a zeroed final result.");

  a_emit_from_search: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ($past(state) == ST_SEARCH || $past(state) == ST_EMIT))
    else $error("Emit step entered without a finished search.");

endmodule

@@ hdl/pms_cell.sv @@
// One vertex cell: row weight shift stage, best edge state and candidate compare stage.
module pms_cell #(
  parameter int VERTICES    = 16,
  parameter int WEIGHT_BITS = 16,
  parameter int IDX         = 0
) (
  input  logic                            clk,
  input  pms_pkg::cell_ctrl_t             ctrl,
  input  logic [$clog2(VERTICES)-1:0]     k,
  input  logic [WEIGHT_BITS-1:0]          w_in,
  output logic [WEIGHT_BITS-1:0]          w_out,
  input  logic                            cin_vld,
  input  logic [WEIGHT_BITS-1:0]          cin_cost,
  input  logic [$clog2(VERTICES)-1:0]     cin_idx,
  input  logic [$clog2(VERTICES)-1:0]     cin_par,
  output logic                            cout_vld,
  output logic [WEIGHT_BITS-1:0]          cout_cost,
  output logic [$clog2(VERTICES)-1:0]     cout_idx,
  output logic [$clog2(VERTICES)-1:0]     cout_par
);
  import pms_pkg::*;

  localparam int VB = $clog2(VERTICES);
  localparam logic [VB-1:0] MY_IDX = VB'(IDX);
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

  logic [WEIGHT_BITS-1:0] w;
  logic [WEIGHT_BITS-1:0] best;
  logic [VB-1:0]          par;
  logic                   intree;
  logic                   own_vld;
  logic                   take_own;
  logic                   is_k;

  assign w_out    = w;
  assign is_k     = (k == MY_IDX);
  assign own_vld  = !intree && (best < NO_EDGE);
  assign take_own = own_vld && (!cin_vld || (best < cin_cost));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      w <= w_in;
    end
    if (ctrl.update) begin
      if (ctrl.init) begin
        best   <= w;
        par    <= k;
        intree <= is_k;
      end else begin
        if (!intree && !is_k && (w < best)) begin
          best <= w;
          par  <= k;
        end
        intree <= intree | is_k;
      end
    end
    if (take_own) begin
      cout_vld  <= 1'b1;
      cout_cost <= best;
      cout_idx  <= MY_IDX;
      cout_par  <= par;
    end else begin
      cout_vld  <= cin_vld;
      cout_cost <= cin_cost;
      cout_idx  <= cin_idx;
      cout_par  <= cin_par;
    end
  end

endmodule
